/* hdl/spcp_pkg.sv */
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared constants for the segment crossing point pipeline.
// ----------------------------------------------------------------------------
package spcp_pkg;

  localparam int unsigned CoordBitsDef = 16;

endpackage

/* hdl/segment_proper_crossing_point.sv */
// ----------------------------------------------------------------------------
// segment_proper_crossing_point
// Proper crossing test of two integer segments AB and CD with the crossing
// point by Cramer's rule, ceiling on x, round half away from zero on y.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy_o is always low.
// Five arithmetic stages, one restoring divider stage per quotient bit
// (COORD_BITS + 1 of them, x and y in parallel), one output stage.
// Reset clears all valid bits; no results are pending after reset.
module segment_proper_crossing_point #(
  parameter int unsigned COORD_BITS = spcp_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] first_start_x_i,
  input  logic        [COORD_BITS-2:0] first_start_y_i,
  input  logic signed [COORD_BITS-1:0] first_end_x_i,
  input  logic        [COORD_BITS-2:0] first_end_y_i,
  input  logic signed [COORD_BITS-1:0] second_start_x_i,
  input  logic        [COORD_BITS-2:0] second_start_y_i,
  input  logic signed [COORD_BITS-1:0] second_end_x_i,
  input  logic        [COORD_BITS-2:0] second_end_y_i,
  output logic                         valid_o,
  output logic                         crosses_o,
  output logic signed [COORD_BITS-1:0] cross_x_o,
  output logic        [COORD_BITS-2:0] cross_y_o
);
  import spcp_pkg::*;

  localparam int unsigned W   = COORD_BITS;
  localparam int unsigned XW  = W + 1;
  localparam int unsigned PW  = 2 * W + 2;
  localparam int unsigned CW  = 2 * W + 3;
  localparam int unsigned NW  = 3 * W + 5;
  localparam int unsigned Q   = W + 1;
  localparam int unsigned LAT = Q + 6;

  typedef struct packed {
    logic                hit;
    logic                negx;
    logic                negy;
    logic signed [W-1:0] bx;
    logic        [W-2:0] by;
    logic signed [W-1:0] dx;
    logic        [W-2:0] dy;
  } meta_t;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // stage 1: differences
  logic signed [XW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  assign ax = XW'(first_start_x_i);
  assign bx = XW'(first_end_x_i);
  assign cx = XW'(second_start_x_i);
  assign dx = XW'(second_end_x_i);
  assign ay = $signed({2'b00, first_start_y_i});
  assign by = $signed({2'b00, first_end_y_i});
  assign cy = $signed({2'b00, second_start_y_i});
  assign dy = $signed({2'b00, second_end_y_i});

  logic                 s1_v_q;
  logic signed [XW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [XW-1:0] cxbx_q, cyby_q, dxbx_q, dyby_q, axdx_q, aydy_q, bxdx_q, bydy_q;
  logic signed [XW-1:0] ax1_q, ay1_q, cx1_q, cy1_q;
  meta_t                m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= by - ay;
    b1_q   <= ax - bx;
    a2_q   <= dy - cy;
    b2_q   <= cx - dx;
    cxbx_q <= cx - bx;
    cyby_q <= cy - by;
    dxbx_q <= dx - bx;
    dyby_q <= dy - by;
    axdx_q <= ax - dx;
    aydy_q <= ay - dy;
    bxdx_q <= bx - dx;
    bydy_q <= by - dy;
    ax1_q  <= ax;
    ay1_q  <= ay;
    cx1_q  <= cx;
    cy1_q  <= cy;
    m1_q   <= '{hit: 1'b0, negx: 1'b0, negy: 1'b0,
                bx: first_end_x_i, by: first_end_y_i,
                dx: second_end_x_i, dy: second_end_y_i};
  end

  // stage 2: products
  logic                 s2_v_q;
  logic signed [PW-1:0] t1a_q, t1b_q, t2a_q, t2b_q, t3a_q, t3b_q, t4a_q, t4b_q;
  logic signed [PW-1:0] c1a_q, c1b_q, c2a_q, c2b_q, da_q, db_q;
  logic signed [XW-1:0] a1_2_q, b1_2_q, a2_2_q, b2_2_q;
  meta_t                m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1a_q  <= PW'(a1_q) * PW'(cxbx_q);
    t1b_q  <= PW'(b1_q) * PW'(cyby_q);
    t2a_q  <= PW'(a1_q) * PW'(dxbx_q);
    t2b_q  <= PW'(b1_q) * PW'(dyby_q);
    t3a_q  <= PW'(a2_q) * PW'(axdx_q);
    t3b_q  <= PW'(b2_q) * PW'(aydy_q);
    t4a_q  <= PW'(a2_q) * PW'(bxdx_q);
    t4b_q  <= PW'(b2_q) * PW'(bydy_q);
    c1a_q  <= PW'(a1_q) * PW'(ax1_q);
    c1b_q  <= PW'(b1_q) * PW'(ay1_q);
    c2a_q  <= PW'(a2_q) * PW'(cx1_q);
    c2b_q  <= PW'(b2_q) * PW'(cy1_q);
    da_q   <= PW'(a1_q) * PW'(b2_q);
    db_q   <= PW'(a2_q) * PW'(b1_q);
    a1_2_q <= a1_q;
    b1_2_q <= b1_q;
    a2_2_q <= a2_q;
    b2_2_q <= b2_q;
    m2_q   <= m1_q;
  end

  // stage 3: sums, orientation signs
  logic signed [CW-1:0] t1, t2, t3, t4, c1_d, c2_d, det_d;
  logic                 cross_d;
  meta_t                m3_d;
  assign t1    = CW'(t1a_q) + CW'(t1b_q);
  assign t2    = CW'(t2a_q) + CW'(t2b_q);
  assign t3    = CW'(t3a_q) + CW'(t3b_q);
  assign t4    = CW'(t4a_q) + CW'(t4b_q);
  assign c1_d  = CW'(c1a_q) + CW'(c1b_q);
  assign c2_d  = CW'(c2a_q) + CW'(c2b_q);
  assign det_d = CW'(da_q) - CW'(db_q);
  assign cross_d = (t1 != '0) && (t2 != '0) && (t3 != '0) && (t4 != '0)
                && (t1[CW-1] != t2[CW-1]) && (t3[CW-1] != t4[CW-1])
                && (det_d != '0);

  always_comb begin
    m3_d     = m2_q;
    m3_d.hit = cross_d;
  end

  logic                 s3_v_q;
  logic signed [CW-1:0] c1_q, c2_q, det3_q;
  logic signed [XW-1:0] a1_3_q, b1_3_q, a2_3_q, b2_3_q;
  meta_t                m3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q   <= c1_d;
    c2_q   <= c2_d;
    det3_q <= det_d;
    a1_3_q <= a1_2_q;
    b1_3_q <= b1_2_q;
    a2_3_q <= a2_2_q;
    b2_3_q <= b2_2_q;
    m3_q   <= m3_d;
  end

  // stage 4: numerator products
  logic                 s4_v_q;
  logic signed [NW-1:0] nxa_q, nxb_q, nya_q, nyb_q;
  logic signed [CW-1:0] det4_q;
  meta_t                m4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nxa_q  <= NW'(b2_3_q) * NW'(c1_q);
    nxb_q  <= NW'(b1_3_q) * NW'(c2_q);
    nya_q  <= NW'(a1_3_q) * NW'(c2_q);
    nyb_q  <= NW'(a2_3_q) * NW'(c1_q);
    det4_q <= det3_q;
    m4_q   <= m3_q;
  end

  // stage 5: numerators, magnitudes, quotient signs
  logic signed [NW-1:0] nx, ny;
  logic                 dneg;
  meta_t                md0_d;
  assign nx   = nxa_q - nxb_q;
  assign ny   = nya_q - nyb_q;
  assign dneg = det4_q[CW-1];

  always_comb begin
    md0_d      = m4_q;
    md0_d.negx = nx[NW-1] ^ dneg;
    md0_d.negy = ny[NW-1] ^ dneg;
  end

  logic          dv_v_q [Q+1];
  logic [NW-1:0] remx_q [Q+1];
  logic [NW-1:0] remy_q [Q+1];
  logic [Q-1:0]  qx_q   [Q+1];
  logic [Q-1:0]  qy_q   [Q+1];
  logic [CW-1:0] den_q  [Q+1];
  meta_t         md_q   [Q+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    remx_q[0] <= nx[NW-1] ? NW'(-nx) : NW'(nx);
    remy_q[0] <= ny[NW-1] ? NW'(-ny) : NW'(ny);
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    den_q[0]  <= dneg ? CW'(-det4_q) : CW'(det4_q);
    md_q[0]   <= md0_d;
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < Q; k++) begin : g_div
    localparam int unsigned Sh = Q - 1 - k;
    logic [NW-1:0] dsh;
    logic          gex, gey;
    assign dsh = NW'(den_q[k]) << Sh;
    assign gex = remx_q[k] >= dsh;
    assign gey = remy_q[k] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      remx_q[k+1] <= gex ? remx_q[k] - dsh : remx_q[k];
      remy_q[k+1] <= gey ? remy_q[k] - dsh : remy_q[k];
      qx_q[k+1]   <= qx_q[k] | (Q'(gex) << Sh);
      qy_q[k+1]   <= qy_q[k] | (Q'(gey) << Sh);
      den_q[k+1]  <= den_q[k];
      md_q[k+1]   <= md_q[k];
    end
  end

  // output stage: rounding, endpoint clamp
  meta_t               mf;
  logic signed [Q:0]   qxs, qys, ix, iy, iy_c, bxs, dxs;
  logic                rx_nz, ry_up;
  logic [NW-1:0]       ry2;

  assign mf    = md_q[Q];
  assign qxs   = $signed({1'b0, qx_q[Q]});
  assign qys   = $signed({1'b0, qy_q[Q]});
  assign rx_nz = remx_q[Q] != '0;
  assign ry2   = remy_q[Q] << 1;
  assign ry_up = ry2 >= NW'(den_q[Q]);
  assign ix    = mf.negx ? -qxs : qxs + (Q+1)'(rx_nz);
  assign iy    = mf.negy ? -(qys + (Q+1)'(ry_up)) : qys + (Q+1)'(ry_up);
  assign bxs   = (Q+1)'(mf.bx);
  assign dxs   = (Q+1)'(mf.dx);

  always_comb begin
    iy_c = iy;
    priority if (ix == bxs) begin
      if ($signed({3'b000, mf.by}) < iy) iy_c = $signed({3'b000, mf.by});
    end else if (ix == dxs) begin
      if ($signed({3'b000, mf.dy}) < iy) iy_c = $signed({3'b000, mf.dy});
    end else begin
      iy_c = iy;
    end
  end

  logic                valid_q, crosses_q;
  logic signed [W-1:0] cross_x_q;
  logic        [W-2:0] cross_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_v_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    crosses_q <= mf.hit;
    cross_x_q <= mf.hit ? ix[W-1:0] : '0;
    cross_y_q <= mf.hit ? iy_c[W-2:0] : '0;
  end

  assign valid_o   = valid_q;
  assign crosses_o = crosses_q;
  assign cross_x_o = cross_x_q;
  assign cross_y_o = cross_y_q;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, LAT))
    else $error("result without request");
  a_no_cross_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !crosses_o) |-> (cross_x_o == '0 && cross_y_o == '0))
    else $error("point not zero without crossing");
  a_div_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |=> dv_v_q[0])
    else $error("divider lost a request");

endmodule

/* tb/segment_proper_crossing_point_test.sv */
// ----------------------------------------------------------------------------
// segment_proper_crossing_point_test
// Streams segment pairs into the crossing point pipeline with random start
// gaps and checks every result against an in-bench integer predictor.
// ----------------------------------------------------------------------------
module segment_proper_crossing_point_test;

  localparam int unsigned CB = spcp_pkg::CoordBitsDef;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic signed [CB-1:0] ax;
    logic [CB-2:0] ay;
    logic signed [CB-1:0] bx;
    logic [CB-2:0] by;
    logic signed [CB-1:0] cx;
    logic [CB-2:0] cy;
    logic signed [CB-1:0] dx;
    logic [CB-2:0] dy;
  } seg_pair_t;

  typedef struct packed {
    logic crosses;
    logic signed [CB-1:0] px;
    logic [CB-2:0] py;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  seg_pair_t req = '0;
  logic valid_o, crosses_o;
  logic signed [CB-1:0] cross_x_o;
  logic [CB-2:0] cross_y_o;

  seg_pair_t pending_q[$];
  crossing_t expected_q[$];
  bit failed = 1'b0;
  bit stim_done = 1'b0;
  bit no_idle = 1'b0;
  int idle_cnt = 0;
  int quiet_cnt = 0;

  segment_proper_crossing_point u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_start_x_i(req.ax), .first_start_y_i(req.ay),
    .first_end_x_i(req.bx), .first_end_y_i(req.by),
    .second_start_x_i(req.cx), .second_start_y_i(req.cy),
    .second_end_x_i(req.dx), .second_end_y_i(req.dy),
    .valid_o, .crosses_o, .cross_x_o, .cross_y_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int orient(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint a1, b1, c1, a2, b2, c2, det, nx, ny, ix, iy;
    int o1, o2, o3, o4;
    crossing_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
    r = '0;
    o1 = orient(ax, ay, bx, by, cx, cy);
    o2 = orient(ax, ay, bx, by, dx, dy);
    o3 = orient(cx, cy, dx, dy, ax, ay);
    o4 = orient(cx, cy, dx, dy, bx, by);
    if (o1 == 0 || o2 == 0 || o3 == 0 || o4 == 0 || o1 == o2 || o3 == o4) return r;
    a1 = by - ay; b1 = ax - bx; c1 = a1 * ax + b1 * ay;
    a2 = dy - cy; b2 = cx - dx; c2 = a2 * cx + b2 * cy;
    det = a1 * b2 - a2 * b1;
    if (det == 0) return r;
    nx = b2 * c1 - b1 * c2;
    ny = a1 * c2 - a2 * c1;
    if (det < 0) begin
      det = -det; nx = -nx; ny = -ny;
    end
    ix = nx / det;
    if (nx % det > 0) ix++;
    if (ny >= 0) iy = (2 * ny + det) / (2 * det);
    else iy = -((-2 * ny + det) / (2 * det));
    if (ix == bx) begin
      if (by < iy) iy = by;
    end else if (ix == dx) begin
      if (dy < iy) iy = dy;
    end
    r.crosses = 1'b1;
    r.px = ix[CB-1:0];
    r.py = iy[CB-2:0];
    return r;
  endfunction

  function automatic seg_pair_t build_pair(longint ax, longint ay, longint bx, longint by,
                                           longint cx, longint cy, longint dx, longint dy);
    seg_pair_t s;
    s.ax = ax[CB-1:0]; s.ay = ay[CB-2:0]; s.bx = bx[CB-1:0]; s.by = by[CB-2:0];
    s.cx = cx[CB-1:0]; s.cy = cy[CB-2:0]; s.dx = dx[CB-1:0]; s.dy = dy[CB-2:0];
    return s;
  endfunction

  function automatic void queue_pair(seg_pair_t s);
    pending_q.insert(pending_q.size(), s);
  endfunction

  // random pair around a centre point: the second segment passes through it, the first need not
  function automatic seg_pair_t make_crossing(int span);
    longint mx, my, ux, uy, vx, vy;
    mx = longint'($urandom_range(2 * span, 0)) - span;
    my = longint'($urandom_range(32767 - span, span));
    ux = longint'($urandom_range(span, 0));
    uy = longint'($urandom_range(span, 0)) - span / 2;
    vx = longint'($urandom_range(span, 0)) - span;
    vy = longint'($urandom_range(span, 0)) - span / 2;
    if ($urandom_range(1, 0)) ux = -ux;
    return build_pair(mx - ux, my - uy, mx + longint'($urandom_range(span, 1)) * ux / span,
                      my + uy / 2, mx - vx, my - vy, mx + vx, my + vy);
  endfunction

  function automatic seg_pair_t make_random();
    logic [127:0] raw;
    seg_pair_t s;
    raw = {$urandom, $urandom, $urandom, $urandom};
    s = raw[$bits(seg_pair_t)-1:0];
    return s;
  endfunction

  initial begin
    int n;
    seg_pair_t s;
    // directed
    queue_pair(build_pair(0, 0, 10, 10, 0, 10, 10, 0));
    queue_pair(build_pair(-32768, 0, 32767, 32767, -32768, 32767, 32767, 0));
    queue_pair(build_pair(32767, 32767, -32768, 0, 32767, 0, -32768, 32767));
    queue_pair(build_pair(0, 0, 10, 10, 10, 10, 20, 0));
    queue_pair(build_pair(0, 0, 10, 10, 5, 5, 10, 0));
    queue_pair(build_pair(0, 0, 10, 10, 2, 2, 20, 20));
    queue_pair(build_pair(0, 0, 10, 10, 20, 20, 30, 30));
    queue_pair(build_pair(0, 0, 10, 0, 0, 5, 10, 5));
    queue_pair(build_pair(3, 3, 3, 3, 0, 0, 6, 6));
    queue_pair(build_pair(3, 3, 3, 3, 3, 3, 3, 3));
    queue_pair(build_pair(0, 0, 3, 1, 0, 1, 3, 0));
    queue_pair(build_pair(0, 0, 2, 3, 0, 3, 3, 0));
    queue_pair(build_pair(-7, 1, 4, 9, -5, 8, 6, 2));
    queue_pair(build_pair(1, 0, 0, 7, 0, 0, 5, 7));
    queue_pair(build_pair(-1, 0, -3, 5, -4, 1, 0, 3));
    queue_pair(build_pair(0, 32767, 1, 0, 0, 0, 1, 32767));
    queue_pair(build_pair(-32768, 100, 32767, 101, 0, 0, 1, 32767));
    queue_pair(build_pair(0, 0, 9, 2, 0, 1, 9, 1));
    queue_pair(build_pair(5, 5, 0, 0, 10, 0, 0, 10));
    queue_pair(build_pair(0, 4, 8, 0, 0, 0, 8, 4));
    queue_pair(build_pair(-1, 0, -1, 32767, -32768, 16000, 32767, 16001));
    for (n = 0; n < 1150; n++) begin
      case ($urandom_range(9, 0))
        0, 1: s = make_random();
        2, 3: s = make_crossing(6);
        4, 5: s = make_crossing(300);
        6: s = make_crossing(16383);
        default: s = make_crossing(2000);
      endcase
      queue_pair(s);
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_q.insert(expected_q.size(), predict_crossing(req));
        void'(pending_q.pop_front());
      end
      no_idle <= (pending_q.size() < 150);
      if (idle_cnt > 0) begin
        idle_cnt <= idle_cnt - 1;
        start_i <= 1'b0;
      end else if (pending_q.size() == 0) begin
        start_i <= 1'b0;
        stim_done <= 1'b1;
      end else if (!no_idle && $urandom_range(15, 0) == 0) begin
        idle_cnt <= $urandom_range(16, 0);
        start_i <= 1'b0;
      end else begin
        start_i <= 1'b1;
        req <= pending_q[0];
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    crossing_t exp_r;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result crosses=%0b x=%0d y=%0d",
                 $time, crosses_o, cross_x_o, cross_y_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (crosses_o !== exp_r.crosses) begin
          $display("%0t: crosses expected %0b actual %0b", $time, exp_r.crosses, crosses_o);
          failed = 1'b1;
        end
        if (cross_x_o !== exp_r.px) begin
          $display("%0t: cross_x expected %0d actual %0d", $time, exp_r.px, cross_x_o);
          failed = 1'b1;
        end
        if (cross_y_o !== exp_r.py) begin
          $display("%0t: cross_y expected %0d actual %0d", $time, exp_r.py, cross_y_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o || (start_i && !busy_o)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_q.size() == 0);
    repeat (CB + 20) @(posedge clk_i);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/spcp_pkg.sv
hdl/segment_proper_crossing_point.sv
tb/segment_proper_crossing_point_test.sv
